/* hw/rtl/cct_pkg.sv */
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, constants and calendar helper functions for the calendar
// clock tick unit.
// ----------------------------------------------------------------------------
package cct_pkg;

    // field widths
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    // stream data widths (fields packed from bit 0, padded to whole bytes)
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 48;

    // calendar limits
    localparam logic [YEAR_W-1:0]   YEAR_MAX     = 14'd16383;
    localparam logic [YEAR_W-1:0]   YEAR_RUN_MIN = 14'd2000;
    localparam logic [6:0]          SEC_PER_MIN  = 7'd60;
    localparam logic [6:0]          MIN_PER_HOUR = 7'd60;
    localparam logic [5:0]          HOUR_PER_DAY = 6'd24;
    localparam logic [4:0]          MONTH_LAST   = 5'd12;
    localparam logic [DAY_W-1:0]    DAY_FIRST    = 5'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;

    // month codes with short lengths
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    // month lengths
    localparam logic [DAY_W-1:0] DAYS_LONG      = 5'd31;
    localparam logic [DAY_W-1:0] DAYS_SHORT     = 5'd30;
    localparam logic [DAY_W-1:0] DAYS_FEB       = 5'd28;
    localparam logic [DAY_W-1:0] DAYS_FEB_LEAP  = 5'd29;

    // multiplicative inverse of 25 modulo 2^14 (25 * 7209 = 11 * 2^14 + 1);
    // a multiple of 25 maps onto 0..floor((2^14-1)/25)
    localparam logic [YEAR_W-1:0] DIV25_INV   = 14'd7209;
    localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

    // item kind carried in tuser
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // one input item
    typedef struct packed {
        logic                valid;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
        op_t                 op;
    } item_t;

    // one result item
    typedef struct packed {
        logic                running;
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } result_t;

    // gregorian leap-year test without a divider
    function automatic logic year_is_leap(input logic [YEAR_W-1:0] year);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = year * DIV25_INV;
        div25 = (prod <= DIV25_LIMIT);
        return ((year[1:0] == 2'b00) && !div25) || ((year[3:0] == 4'b0000) && div25);
    endfunction

    // days in a month, unknown month codes count as long months
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month,
                                                      input logic               leap);
        logic [DAY_W-1:0] len;
        len = DAYS_LONG;
        if (month == MONTH_FEB) begin
            len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
        end else if (month inside {MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV}) begin
            len = DAYS_SHORT;
        end
        return len;
    endfunction

endpackage

/* hw/rtl/cct_in_stage.sv */
// ----------------------------------------------------------------------------
// cct_in_stage
// Input register: captures one item from the slave stream and holds it until
// the calendar stage takes it.
// ----------------------------------------------------------------------------
module cct_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  cct_pkg::item_t in_item,
    output logic           hold_valid,
    input  logic           hold_take,
    output cct_pkg::item_t hold_item
);

    logic           vld_reg;
    logic           vld_next;
    cct_pkg::item_t item_reg;

    // room when empty or when the held item leaves this cycle
    assign in_ready = !vld_reg || hold_take;

    always_comb begin
        vld_next = vld_reg;
        if (in_valid && in_ready) begin
            vld_next = 1'b1;
        end else if (hold_take) begin
            vld_next = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = vld_reg;
    assign hold_item  = item_reg;

endmodule

/* hw/rtl/cct_calendar.sv */
// ----------------------------------------------------------------------------
// cct_calendar
// Time-of-day and date registers with the one-second carry chain, the leap
// year test and load handling. Produces the result for the item applied.
// ----------------------------------------------------------------------------
module cct_calendar (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             apply,
    input  cct_pkg::item_t   item,
    output cct_pkg::result_t result
);

    logic [cct_pkg::YEAR_W-1:0]   year_reg,   year_next;
    logic [cct_pkg::MONTH_W-1:0]  month_reg,  month_next;
    logic [cct_pkg::DAY_W-1:0]    day_reg,    day_next;
    logic [cct_pkg::HOUR_W-1:0]   hour_reg,   hour_next;
    logic [cct_pkg::MINUTE_W-1:0] minute_reg, minute_next;
    logic [cct_pkg::SECOND_W-1:0] second_reg, second_next;
    logic                         tvalid_reg, tvalid_next;

    logic                         running;
    logic [6:0]                   sec_inc;
    logic [6:0]                   min_inc;
    logic [5:0]                   hour_inc;
    logic [5:0]                   day_inc;
    logic [4:0]                   month_inc;
    logic [cct_pkg::DAY_W-1:0]    mlen;
    logic                         sec_wrap, min_wrap, hour_wrap, day_wrap, month_wrap;
    logic                         c_min, c_hour, c_day, c_month, c_year;

    // clock runs only with a valid time from year 2000 on
    assign running = tvalid_reg && (year_reg >= cct_pkg::YEAR_RUN_MIN);

    // incremented fields and their wrap tests
    assign sec_inc   = {1'b0, second_reg} + 7'd1;
    assign min_inc   = {1'b0, minute_reg} + 7'd1;
    assign hour_inc  = {1'b0, hour_reg} + 6'd1;
    assign day_inc   = {1'b0, day_reg} + 6'd1;
    assign month_inc = {1'b0, month_reg} + 5'd1;
    assign mlen      = cct_pkg::month_length(month_reg, cct_pkg::year_is_leap(year_reg));

    assign sec_wrap   = (sec_inc >= cct_pkg::SEC_PER_MIN);
    assign min_wrap   = (min_inc >= cct_pkg::MIN_PER_HOUR);
    assign hour_wrap  = (hour_inc >= cct_pkg::HOUR_PER_DAY);
    assign day_wrap   = (day_inc > {1'b0, mlen});
    assign month_wrap = (month_inc > cct_pkg::MONTH_LAST);

    // carry chain from seconds up to years
    assign c_min   = sec_wrap;
    assign c_hour  = c_min && min_wrap;
    assign c_day   = c_hour && hour_wrap;
    assign c_month = c_day && day_wrap;
    assign c_year  = c_month && month_wrap;

    // next state for a load, a tick or an ignored tick
    always_comb begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        tvalid_next = tvalid_reg;
        if (item.op == cct_pkg::OP_LOAD) begin
            year_next   = item.year;
            month_next  = item.month;
            day_next    = item.day;
            hour_next   = item.hour;
            minute_next = item.minute;
            second_next = item.second;
            tvalid_next = item.valid;
        end else if (running) begin
            second_next = sec_wrap ? '0 : sec_inc[cct_pkg::SECOND_W-1:0];
            if (c_min) begin
                minute_next = min_wrap ? '0 : min_inc[cct_pkg::MINUTE_W-1:0];
            end
            if (c_hour) begin
                hour_next = hour_wrap ? '0 : hour_inc[cct_pkg::HOUR_W-1:0];
            end
            if (c_day) begin
                day_next = day_wrap ? cct_pkg::DAY_FIRST : day_inc[cct_pkg::DAY_W-1:0];
            end
            if (c_month) begin
                month_next = month_wrap ? cct_pkg::MONTH_FIRST
                                        : month_inc[cct_pkg::MONTH_W-1:0];
            end
            if (c_year && (year_reg != cct_pkg::YEAR_MAX)) begin
                year_next = year_reg + 14'd1;
            end
        end
    end

    // time registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            tvalid_reg <= 1'b0;
        end else if (apply) begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            tvalid_reg <= tvalid_next;
        end
    end

    // result is the time after this item
    always_comb begin
        result.year    = year_next;
        result.month   = month_next;
        result.day     = day_next;
        result.hour    = hour_next;
        result.minute  = minute_next;
        result.second  = second_next;
        result.running = tvalid_next && (year_next >= cct_pkg::YEAR_RUN_MIN);
    end

`ifndef SYNTHESIS
    // a tick while stopped leaves the time untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        apply && (item.op == cct_pkg::OP_TICK) && !running
        |=> $stable(year_reg) && $stable(month_reg) && $stable(day_reg) &&
            $stable(hour_reg) && $stable(minute_reg) && $stable(second_reg))
        else $error("cct_calendar: stopped clock advanced");

    // a load takes the given year and validity
    assert property (@(posedge aclk) disable iff (!aresetn)
        apply && (item.op == cct_pkg::OP_LOAD)
        |=> (year_reg == $past(item.year)) && (tvalid_reg == $past(item.valid)))
        else $error("cct_calendar: load not taken");

    // a running tick below the minute boundary only bumps the seconds
    assert property (@(posedge aclk) disable iff (!aresetn)
        apply && (item.op == cct_pkg::OP_TICK) && running && !sec_wrap
        |=> (second_reg == $past(second_reg) + 6'd1) && $stable(minute_reg))
        else $error("cct_calendar: plain tick carried");

    // the validity flag never changes on a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        apply && (item.op == cct_pkg::OP_TICK) |=> $stable(tvalid_reg))
        else $error("cct_calendar: tick changed validity");
`endif

endmodule

/* hw/rtl/cct_out_stage.sv */
// ----------------------------------------------------------------------------
// cct_out_stage
// Result register: holds one result for the master stream until it is taken.
// ----------------------------------------------------------------------------
module cct_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  cct_pkg::result_t load_result,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output cct_pkg::result_t out_result
);

    logic             vld_reg;
    logic             vld_next;
    cct_pkg::result_t result_reg;

    // free when empty or when the held result is taken this cycle
    assign space = !vld_reg || out_ready;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (out_ready) begin
            vld_next = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = vld_reg;
    assign out_result = result_reg;

endmodule

/* hw/rtl/calendar_clock_tick_unit.sv */
// ----------------------------------------------------------------------------
// calendar_clock_tick_unit
// Real-time calendar clock: load items set the date and time, tick items
// advance it by one second while it runs; every item returns the time after it.
// ----------------------------------------------------------------------------
// path from input acceptance to result valid: input register, then result
// register behind the calendar carry logic
// throughput: one item per cycle, limited only by the result stream's tready
// reset: aresetn clears the date, time and validity flag, so the clock starts
// stopped until a valid load from year 2000 on
// ----------------------------------------------------------------------------
module calendar_clock_tick_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
    // second[39:34], load_valid[40], zero[47:41]
    input  logic [cct_pkg::IN_DATA_W-1:0]  s_tdata,
    // op[0]: 0 = tick, 1 = load
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cur_year[13:0], cur_month[17:14], cur_day[22:18], cur_hour[27:23],
    // cur_minute[33:28], cur_second[39:34], running[40], zero[47:41]
    output logic [cct_pkg::OUT_DATA_W-1:0] m_tdata
);

    cct_pkg::item_t   in_item;
    cct_pkg::item_t   hold_item;
    cct_pkg::result_t calc_result;
    cct_pkg::result_t out_result;
    logic             hold_valid;
    logic             out_space;
    logic             advance;

    // unpack the slave stream
    always_comb begin
        in_item.op     = cct_pkg::op_t'(s_tuser);
        in_item.year   = s_tdata[13:0];
        in_item.month  = s_tdata[17:14];
        in_item.day    = s_tdata[22:18];
        in_item.hour   = s_tdata[27:23];
        in_item.minute = s_tdata[33:28];
        in_item.second = s_tdata[39:34];
        in_item.valid  = s_tdata[40];
    end

    // an item moves on when held and the result register has room
    assign advance = hold_valid && out_space;

    cct_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .hold_valid (hold_valid),
        .hold_take  (advance),
        .hold_item  (hold_item)
    );

    cct_calendar u_cal (
        .aclk    (aclk),
        .aresetn (aresetn),
        .apply   (advance),
        .item    (hold_item),
        .result  (calc_result)
    );

    cct_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (advance),
        .load_result (calc_result),
        .space       (out_space),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    // pack the master stream
    assign m_tdata = {7'd0, out_result.running, out_result.second, out_result.minute,
                      out_result.hour, out_result.day, out_result.month, out_result.year};

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for calendar_clock_tick_unit. Load and tick items go
// in on the input stream, with random gaps in most tests. Each accepted item
// updates a calendar kept inside the bench, which gives the expected time
// and running flag. The result stream is checked field by field, with random
// back pressure on the result side in most tests.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_TAIL  = 6;

    // load fields as they sit in tdata, year in the lowest bits
    typedef struct packed {
        logic                         valid;
        logic [cct_pkg::SECOND_W-1:0] second;
        logic [cct_pkg::MINUTE_W-1:0] minute;
        logic [cct_pkg::HOUR_W-1:0]   hour;
        logic [cct_pkg::DAY_W-1:0]    day;
        logic [cct_pkg::MONTH_W-1:0]  month;
        logic [cct_pkg::YEAR_W-1:0]   year;
    } load_word_t;

    localparam int unsigned WORD_W   = $bits(load_word_t);
    localparam int unsigned RESULT_W = $bits(cct_pkg::result_t);

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [cct_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [cct_pkg::OUT_DATA_W-1:0] m_tdata;

    // calendar kept by the bench, updated on every accepted item
    logic [cct_pkg::YEAR_W-1:0]   cal_year   = '0;
    logic [cct_pkg::MONTH_W-1:0]  cal_month  = '0;
    logic [cct_pkg::DAY_W-1:0]    cal_day    = '0;
    logic [cct_pkg::HOUR_W-1:0]   cal_hour   = '0;
    logic [cct_pkg::MINUTE_W-1:0] cal_minute = '0;
    logic [cct_pkg::SECOND_W-1:0] cal_second = '0;
    logic                         cal_valid  = 1'b0;

    cct_pkg::result_t due_times[$];
    int unsigned      error_count = 0;
    int unsigned      cycle_count = 0;
    bit               tx_idle_on  = 1'b1;
    bit               rx_idle_on  = 1'b1;
    int unsigned      rx_wait     = 0;
    int unsigned      rx_hold     = 0;

    calendar_clock_tick_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // calendar arithmetic
    // ------------------------------------------------------------------------

    function automatic int unsigned month_day_count(
        input logic [cct_pkg::MONTH_W-1:0] month,
        input logic [cct_pkg::YEAR_W-1:0]  year);
        bit leap;
        leap = ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
        if (month == cct_pkg::MONTH_FEB) begin
            return leap ? cct_pkg::DAYS_FEB_LEAP : cct_pkg::DAYS_FEB;
        end
        if (month == cct_pkg::MONTH_APR || month == cct_pkg::MONTH_JUN ||
            month == cct_pkg::MONTH_SEP || month == cct_pkg::MONTH_NOV) begin
            return cct_pkg::DAYS_SHORT;
        end
        return cct_pkg::DAYS_LONG;
    endfunction

    function automatic bit clock_running();
        return cal_valid && (cal_year >= cct_pkg::YEAR_RUN_MIN);
    endfunction

    // one second forward; out-of-range fields are incremented before the compare
    function automatic void advance_second();
        int unsigned nxt;
        nxt = cal_second + 1;
        if (nxt < cct_pkg::SEC_PER_MIN) begin
            cal_second = nxt[cct_pkg::SECOND_W-1:0];
            return;
        end
        cal_second = '0;
        nxt = cal_minute + 1;
        if (nxt < cct_pkg::MIN_PER_HOUR) begin
            cal_minute = nxt[cct_pkg::MINUTE_W-1:0];
            return;
        end
        cal_minute = '0;
        nxt = cal_hour + 1;
        if (nxt < cct_pkg::HOUR_PER_DAY) begin
            cal_hour = nxt[cct_pkg::HOUR_W-1:0];
            return;
        end
        cal_hour = '0;
        nxt = cal_day + 1;
        if (nxt <= month_day_count(cal_month, cal_year)) begin
            cal_day = nxt[cct_pkg::DAY_W-1:0];
            return;
        end
        cal_day = cct_pkg::DAY_FIRST;
        nxt = cal_month + 1;
        if (nxt <= cct_pkg::MONTH_LAST) begin
            cal_month = nxt[cct_pkg::MONTH_W-1:0];
            return;
        end
        cal_month = cct_pkg::MONTH_FIRST;
        if (cal_year != cct_pkg::YEAR_MAX) begin
            cal_year = cal_year + 1'b1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side: predict the time after every accepted item
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        load_word_t       w;
        cct_pkg::result_t due;
        if (aresetn && s_tvalid && s_tready) begin
            w = s_tdata[WORD_W-1:0];
            if (s_tuser == cct_pkg::OP_LOAD) begin
                cal_year   = w.year;
                cal_month  = w.month;
                cal_day    = w.day;
                cal_hour   = w.hour;
                cal_minute = w.minute;
                cal_second = w.second;
                cal_valid  = w.valid;
            end else if (clock_running()) begin
                advance_second();
            end
            due.year    = cal_year;
            due.month   = cal_month;
            due.day     = cal_day;
            due.hour    = cal_hour;
            due.minute  = cal_minute;
            due.second  = cal_second;
            due.running = clock_running();
            due_times.push_back(due);
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stalls and the field check
    // ------------------------------------------------------------------------

    // ready may drop at random after each item taken, while rx_idle_on is set
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (rx_wait != 0) begin
            rx_wait <= rx_wait - 1;
        end else if (m_tvalid && m_tready && rx_idle_on) begin
            rx_hold = $urandom_range(0, 4);
            m_tready <= (rx_hold == 0);
            rx_wait  <= (rx_hold == 0) ? 0 : rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    always @(posedge aclk) begin
        cct_pkg::result_t got;
        cct_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[RESULT_W-1:0];
            if (due_times.size() == 0) begin
                report_error("result with no item outstanding");
            end else begin
                want = due_times.pop_front();
                check_field("year", got.year, want.year);
                check_field("month", got.month, want.month);
                check_field("day", got.day, want.day);
                check_field("hour", got.hour, want.hour);
                check_field("minute", got.minute, want.minute);
                check_field("second", got.second, want.second);
                check_field("running", got.running, want.running);
                check_field("pad bits", m_tdata[cct_pkg::OUT_DATA_W-1:RESULT_W], 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // one item, after a random gap when tx_idle_on is set; returns at the edge that accepted it
    task automatic send_item(input cct_pkg::op_t op, input load_word_t w);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= cct_pkg::IN_DATA_W'(w);
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
    endtask

    function automatic load_word_t load_word(input int unsigned year, input int unsigned month,
                                             input int unsigned day, input int unsigned hour,
                                             input int unsigned minute,
                                             input int unsigned second, input bit valid);
        load_word_t w;
        w.year   = year[cct_pkg::YEAR_W-1:0];
        w.month  = month[cct_pkg::MONTH_W-1:0];
        w.day    = day[cct_pkg::DAY_W-1:0];
        w.hour   = hour[cct_pkg::HOUR_W-1:0];
        w.minute = minute[cct_pkg::MINUTE_W-1:0];
        w.second = second[cct_pkg::SECOND_W-1:0];
        w.valid  = valid;
        return w;
    endfunction

    function automatic load_word_t noise_word();
        return WORD_W'({$urandom(), $urandom()});
    endfunction

    // tick items carry random load fields, which must be ignored
    task automatic send_ticks(input int unsigned count);
        repeat (count) send_item(cct_pkg::OP_TICK, noise_word());
    endtask

    task automatic load_and_tick(input load_word_t w);
        send_item(cct_pkg::OP_LOAD, w);
        send_item(cct_pkg::OP_TICK, noise_word());
    endtask

    // hold the input side until every item has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_times.size() != 0) @(posedge aclk);
    endtask

    // mostly a valid time close to a carry, so short tick runs reach deep
    function automatic load_word_t random_load();
        load_word_t  w;
        int unsigned yr;
        int unsigned mo;
        int unsigned kind;
        kind = $urandom_range(0, 9);
        case ($urandom_range(0, 5))
            0:       yr = 2000 + $urandom_range(0, 40);
            1:       yr = $urandom_range(cct_pkg::YEAR_RUN_MIN, cct_pkg::YEAR_MAX);
            2:       yr = 100 * $urandom_range(20, 163);
            3:       yr = cct_pkg::YEAR_MAX - $urandom_range(0, 1);
            4:       yr = 4 * $urandom_range(500, 4095);
            default: yr = 1999 - $urandom_range(0, 3);
        endcase
        mo = ($urandom_range(0, 2) == 0) ? cct_pkg::MONTH_LAST : $urandom_range(1, 12);
        w = load_word(yr, mo, 1, 23, 59, 59 - $urandom_range(0, 3), 1'b1);
        w.day = cct_pkg::DAY_W'(month_day_count(w.month, w.year) - $urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) begin
            w.hour   = cct_pkg::HOUR_W'($urandom_range(0, 23));
            w.minute = cct_pkg::MINUTE_W'($urandom_range(0, 59));
        end
        if (kind == 7) begin
            // any bit pattern, out-of-range fields included
            w = noise_word();
        end else if (kind == 8) begin
            w.valid = 1'b0;
        end else if (kind == 9) begin
            w.day    = cct_pkg::DAY_W'($urandom_range(1, 31));
            w.second = cct_pkg::SECOND_W'($urandom_range(0, 59));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset state, stopped clock, leap rules, carries and out-of-range fields
    task automatic test_directed_cases();
        send_ticks(1);
        load_and_tick(load_word(2024, 6, 15, 12, 30, 45, 1'b0));
        load_and_tick(load_word(1999, 12, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2000, 2, 28, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2100, 2, 28, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2023, 12, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(cct_pkg::YEAR_MAX, 12, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2050, 0, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2050, 15, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(2050, 13, 5, 31, 63, 63, 1'b1));
        load_and_tick(load_word(2050, 4, 31, 23, 59, 59, 1'b1));
        load_and_tick(load_word(cct_pkg::YEAR_MAX, 15, 31, 31, 63, 63, 1'b1));
    endtask

    // loads followed by tick runs, with stray items and full drains
    task automatic test_random_calendar(input int unsigned item_count);
        int unsigned sent;
        int unsigned run;
        int unsigned next_drain;
        sent       = 0;
        next_drain = 250;
        while (sent < item_count) begin
            if ($urandom_range(0, 7) == 0) begin
                if ($urandom_range(0, 1) == 0) begin
                    send_item(cct_pkg::OP_LOAD, noise_word());
                end else begin
                    send_ticks(1);
                end
                sent++;
            end
            send_item(cct_pkg::OP_LOAD, random_load());
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130)
                                              : $urandom_range(1, 8);
            send_ticks(run);
            sent += run + 1;
            if (sent >= next_drain) begin
                wait_for_results();
                next_drain += 250;
            end
        end
    endtask

    // full rate on both sides
    task automatic test_back_to_back(input int unsigned item_count);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_calendar(item_count);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // sender at full rate against a stalling receiver
    task automatic test_result_stalls(input int unsigned item_count);
        tx_idle_on = 1'b0;
        test_random_calendar(item_count);
        tx_idle_on = 1'b1;
    endtask

    task automatic finish_run();
        wait_for_results();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (error_count == 0 && due_times.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_calendar(700);
        test_back_to_back(200);
        test_result_stalls(300);
        finish_run();
    end

endmodule
